>>> src/spq_pkg.sv
// spq_pkg: shared constants, codes and control structs of the sorted priority queue.
// Used by the interfaces, controller, datapath and top level; depends on nothing.
`default_nettype none
package spq_pkg;

  localparam int unsigned DepthDefault = 16;

  localparam int unsigned ValueWidth  = 32;
  localparam int unsigned CountWidth  = 5;
  localparam int unsigned StatusWidth = 2;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  localparam logic [StatusWidth-1:0] STATUS_DONE  = 2'd0;
  localparam logic [StatusWidth-1:0] STATUS_FULL  = 2'd1;
  localparam logic [StatusWidth-1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic                   load;
    logic                   do_insert;
    logic                   do_remove;
    logic [StatusWidth-1:0] status;
  } spq_ctrl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } spq_stat_t;

endpackage
`default_nettype wire

>>> src/spq_in_if.sv
// spq_in_if: request channel of the sorted priority queue (valid, ready, cmd, value).
// Depends on spq_pkg for field widths.
`default_nettype none
interface spq_in_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   cmd;
  logic signed [spq_pkg::ValueWidth-1:0]  value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface
`default_nettype wire

>>> src/spq_out_if.sv
// spq_out_if: result channel of the sorted priority queue (valid, ready, result fields).
// Depends on spq_pkg for field widths.
`default_nettype none
interface spq_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [spq_pkg::ValueWidth-1:0]  removed_value;
  logic                                   removed_valid;
  logic signed [spq_pkg::ValueWidth-1:0]  head_value;
  logic        [spq_pkg::CountWidth-1:0]  entry_count;
  logic        [spq_pkg::StatusWidth-1:0] status;

  modport source (output valid, output removed_value, output removed_valid,
                  output head_value, output entry_count, output status, input ready);
  modport sink   (input valid, input removed_value, input removed_valid,
                  input head_value, input entry_count, input status, output ready);
endinterface
`default_nettype wire

>>> src/spq_ctrl.sv
// spq_ctrl: handshake controller; decides each request's operation and status code.
// Depends on spq_pkg; drives spq_dp through spq_ctrl_t and reads spq_stat_t.
`default_nettype none
module spq_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_cmd_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  input  wire spq_pkg::spq_stat_t stat_i,
  output spq_pkg::spq_ctrl_t      ctrl_o
);
  import spq_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_HOLD = 1'b1;

  logic state_q, state_d;
  logic accept;

  assign in_ready_o  = (state_q == ST_IDLE) || out_ready_i;
  assign out_valid_o = (state_q == ST_HOLD);
  assign accept      = in_valid_i && in_ready_o;

  always_comb begin
    ctrl_o.load      = accept;
    ctrl_o.do_insert = 1'b0;
    ctrl_o.do_remove = 1'b0;
    ctrl_o.status    = STATUS_DONE;
    if (in_cmd_i == CMD_INSERT) begin
      if (stat_i.full) begin
        ctrl_o.status = STATUS_FULL;
      end else begin
        ctrl_o.do_insert = accept;
      end
    end else begin
      if (stat_i.empty) begin
        ctrl_o.status = STATUS_EMPTY;
      end else begin
        ctrl_o.do_remove = accept;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_HOLD;
      end
      ST_HOLD: begin
        if (accept) begin
          state_d = ST_HOLD;
        end else if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_one_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctrl_o.do_insert, ctrl_o.do_remove}))
    else $error("insert and remove issued together");

  a_load_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.load |=> out_valid_o)
    else $error("accepted request left no pending result");

  a_full_no_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_o.status == STATUS_FULL) |-> (!ctrl_o.do_insert && in_cmd_i == CMD_INSERT))
    else $error("full status with insert issued");

endmodule
`default_nettype wire

>>> src/spq_dp.sv
// spq_dp: ordered entry registers with parallel compare-and-shift, count and result register.
// Depends on spq_pkg; commanded by spq_ctrl through spq_ctrl_t.
`default_nettype none
module spq_dp #(
  parameter int unsigned DEPTH = spq_pkg::DepthDefault
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire spq_pkg::spq_ctrl_t                      ctrl_i,
  input  wire logic signed [spq_pkg::ValueWidth-1:0]   value_i,
  output spq_pkg::spq_stat_t                           stat_o,
  output logic signed [spq_pkg::ValueWidth-1:0]        removed_value_o,
  output logic                                         removed_valid_o,
  output logic signed [spq_pkg::ValueWidth-1:0]        head_value_o,
  output logic        [spq_pkg::CountWidth-1:0]        entry_count_o,
  output logic        [spq_pkg::StatusWidth-1:0]       status_o
);
  import spq_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic signed [ValueWidth-1:0] ent_q [DEPTH];
  logic signed [ValueWidth-1:0] ent_d [DEPTH];
  logic        [DEPTH-1:0]      lt;
  logic        [CW-1:0]         cnt_q, cnt_d;
  logic        [CW+CountWidth-1:0] cnt_ext;

  assign stat_o.full  = (cnt_q == CW'(DEPTH));
  assign stat_o.empty = (cnt_q == '0);

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      lt[i] = (CW'(i) < cnt_q) && (ent_q[i] < value_i);
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ent_d[i] = ent_q[i];
      if (ctrl_i.do_insert) begin
        if (lt[i]) begin
          ent_d[i] = ent_q[i];
        end else if (i == 0) begin
          ent_d[i] = value_i;
        end else if (lt[i-1]) begin
          ent_d[i] = value_i;
        end else begin
          ent_d[i] = ent_q[i-1];
        end
      end else if (ctrl_i.do_remove && (i < DEPTH - 1)) begin
        ent_d[i] = ent_q[i+1];
      end
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (ctrl_i.do_insert) begin
      cnt_d = cnt_q + CW'(1);
    end else if (ctrl_i.do_remove) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  assign cnt_ext = {{CountWidth{1'b0}}, cnt_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < DEPTH; i++) begin
      ent_q[i] <= ent_d[i];
    end
    if (ctrl_i.load) begin
      removed_value_o <= ctrl_i.do_remove ? ent_q[0] : '0;
      removed_valid_o <= ctrl_i.do_remove;
      head_value_o    <= (cnt_d != '0) ? ent_d[0] : '0;
      entry_count_o   <= cnt_ext[CountWidth-1:0];
      status_o        <= ctrl_i.status;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("entry count above depth");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.do_insert |=> cnt_q == $past(cnt_q) + CW'(1))
    else $error("insert did not grow the count");

  a_remove_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.do_remove |=> (removed_valid_o && removed_value_o == $past(ent_q[0])))
    else $error("remove did not report the old head");

endmodule
`default_nettype wire

>>> src/sorted_priority_queue.sv
// sorted_priority_queue: top level; joins the request/result channels to spq_ctrl and spq_dp.
// Depends on spq_pkg, spq_in_if, spq_out_if, spq_ctrl and spq_dp.
//
// Usage:
//   req_i carries one request: cmd (insert or remove head) and a signed 32-bit value.
//   res_o returns exactly one result per request: removed value and flag, the head
//   after the step, the entry count and a status code (done, full, empty).
//   Entries sit ascending in DEPTH position registers; an insert compares the value
//   against every stored entry in parallel and shifts the tail up by one in the same
//   cycle, a remove shifts all entries down by one.
//   Latency: the result is valid the cycle after the request is accepted.
//   Throughput: one request per cycle while results are taken, set by the combinational
//   compare-and-shift over the position registers; the result register lets a new request
//   enter in the cycle its predecessor's result is taken.
//   Reset: the queue is empty and no result is pending; entry registers need no clearing.
//   Stall: while res_o is held and not taken, req_i.ready drops and the result holds.
`default_nettype none
module sorted_priority_queue #(
  parameter int unsigned DEPTH = spq_pkg::DepthDefault
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  spq_in_if.sink     req_i,
  spq_out_if.source  res_o
);
  import spq_pkg::*;

  spq_ctrl_t ctrl;
  spq_stat_t stat;

  spq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_cmd_i    (req_i.cmd),
    .in_ready_o  (req_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  spq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .value_i         (req_i.value),
    .stat_o          (stat),
    .removed_value_o (res_o.removed_value),
    .removed_valid_o (res_o.removed_valid),
    .head_value_o    (res_o.head_value),
    .entry_count_o   (res_o.entry_count),
    .status_o        (res_o.status)
  );

endmodule
`default_nettype wire

>>> tb/sorted_priority_queue_test.sv
// sorted_priority_queue_test: self-checking bench for sorted_priority_queue; predicts every
// result from a mirror of the sorted entries and checks it field by field under random stalls.
// Depends on spq_pkg, spq_in_if, spq_out_if and the sorted_priority_queue top level.
`default_nettype none
module sorted_priority_queue_test;
  import spq_pkg::*;

  localparam int unsigned DEPTH          = DepthDefault;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned HOLD_OFF_LEN   = 64;

  localparam logic signed [ValueWidth-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [ValueWidth-1:0] VAL_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [ValueWidth-1:0]  removed_value;
    logic                          removed_valid;
    logic signed [ValueWidth-1:0]  head_value;
    logic        [CountWidth-1:0]  entry_count;
    logic        [StatusWidth-1:0] status;
  } queue_result_t;

  logic clk;
  logic rst_n;

  spq_in_if  req_if ();
  spq_out_if res_if ();

  sorted_priority_queue #(.DEPTH(DEPTH)) dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  logic signed [ValueWidth-1:0] held_vals [DEPTH];
  int unsigned                  held_count;
  queue_result_t                pending_results [$];

  bit          req_idle_en;
  bit          res_stall_en;
  int unsigned hold_off_req;
  int unsigned hold_left;
  int unsigned error_count;
  int unsigned request_count;
  int unsigned result_count;
  int unsigned full_rejects;
  int unsigned empty_removes;
  int unsigned idle_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic queue_result_t apply_request(logic cmd, logic signed [ValueWidth-1:0] v);
    queue_result_t r;
    int unsigned   pos;
    r = '0;
    r.status = STATUS_DONE;
    if (cmd == CMD_INSERT) begin
      if (held_count >= DEPTH) begin
        r.status = STATUS_FULL;
      end else begin
        pos = 0;
        while (pos < held_count && held_vals[pos] < v) pos++;
        for (int unsigned i = held_count; i > pos; i--) held_vals[i] = held_vals[i-1];
        held_vals[pos] = v;
        held_count++;
      end
    end else begin
      if (held_count == 0) begin
        r.status = STATUS_EMPTY;
      end else begin
        r.removed_value = held_vals[0];
        r.removed_valid = 1'b1;
        for (int unsigned i = 1; i < held_count; i++) held_vals[i-1] = held_vals[i];
        held_count--;
      end
    end
    r.head_value  = (held_count > 0) ? held_vals[0] : '0;
    r.entry_count = CountWidth'(held_count);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at result %0d: %s got %0d expected %0d", result_count, what, got, want);
    error_count++;
  endtask

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_request(logic cmd, logic signed [ValueWidth-1:0] v);
    queue_result_t r;
    while (req_idle_en && $urandom_range(0, 99) < 32) begin
      req_if.valid = 1'b0;
      @(negedge clk);
    end
    req_if.valid = 1'b1;
    req_if.cmd   = cmd;
    req_if.value = v;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    r = apply_request(cmd, v);
    if (r.status == STATUS_FULL) full_rejects++;
    if (r.status == STATUS_EMPTY) empty_removes++;
    pending_results.push_back(r);
    request_count++;
    @(negedge clk);
  endtask

  task automatic wait_results_drained();
    req_if.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  function automatic logic signed [ValueWidth-1:0] pick_value();
    logic signed [ValueWidth-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: v = $urandom;
      5, 6, 7:       v = $signed(ValueWidth'($urandom_range(0, 8))) - 4;
      8:             v = $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
      default:       v = $urandom_range(0, 1) ? '0 : '1;
    endcase
    return v;
  endfunction

  task automatic send_random(int unsigned n_items, int unsigned insert_pct);
    for (int unsigned i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 99) < insert_pct) send_request(CMD_INSERT, pick_value());
      else send_request(CMD_REMOVE, '0);
    end
  endtask

  task automatic test_remove_on_empty();
    send_request(CMD_REMOVE, 32'sd123);
  endtask

  task automatic test_fill_extremes_and_full();
    logic signed [ValueWidth-1:0] fill_vals [16];
    fill_vals = '{VAL_MAX, VAL_MIN, 32'sd0, -32'sd1, 32'sd1, 32'sh5555_5555, 32'shAAAA_AAAA,
                  32'sd7, 32'sd7, 32'sd7, -32'sd7, VAL_MIN + 1, VAL_MAX - 1, 32'sd100,
                  -32'sd100, 32'sd0};
    for (int unsigned i = 0; i < DEPTH; i++) send_request(CMD_INSERT, fill_vals[i % 16]);
    send_request(CMD_INSERT, 32'sd3);
  endtask

  task automatic test_remove_ordered();
    repeat (6) send_request(CMD_REMOVE, '1);
    wait_results_drained();
  endtask

  task automatic test_random_phases();
    req_idle_en  = 1'b1;
    res_stall_en = 1'b1;
    for (int unsigned p = 0; p < 20; p++) begin
      case (p % 3)
        0:       send_random(40, 80);
        1:       send_random(40, 20);
        default: send_random(40, 50);
      endcase
    end
  endtask

  task automatic test_no_idle_stretch();
    req_idle_en  = 1'b0;
    res_stall_en = 1'b0;
    send_random(150, 75);
    send_random(150, 30);
  endtask

  task automatic test_backpressure();
    req_idle_en  = 1'b0;
    res_stall_en = 1'b1;
    hold_off_req = HOLD_OFF_LEN;
    send_random(30, 60);
  endtask

  task automatic test_sender_pause();
    wait_results_drained();
    req_idle_en  = 1'b1;
    res_stall_en = 1'b1;
    for (int unsigned p = 0; p < 10; p++) send_random(40, (p % 2 == 0) ? 70 : 30);
  endtask

  initial begin
    res_if.ready = 1'b0;
    hold_left    = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req > 0) begin
        hold_left    = hold_off_req;
        hold_off_req = 0;
      end
      if (hold_left > 0) begin
        res_if.ready = 1'b0;
        hold_left--;
      end else begin
        res_if.ready = !(res_stall_en && $urandom_range(0, 99) < 32);
      end
    end
  end

  always @(posedge clk) begin
    queue_result_t want;
    if (res_if.valid && res_if.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, head_value", res_if.head_value, 0);
      end else begin
        want = pending_results.pop_front();
        if (res_if.removed_value !== want.removed_value)
          report_mismatch("removed_value", res_if.removed_value, want.removed_value);
        if (res_if.removed_valid !== want.removed_valid)
          report_mismatch("removed_valid", res_if.removed_valid, want.removed_valid);
        if (res_if.head_value !== want.head_value)
          report_mismatch("head_value", res_if.head_value, want.head_value);
        if (res_if.entry_count !== want.entry_count)
          report_mismatch("entry_count", res_if.entry_count, want.entry_count);
        if (res_if.status !== want.status)
          report_mismatch("status", res_if.status, want.status);
      end
      result_count++;
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("watchdog: %0d cycles without a handshake", idle_cycles);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rst_n         = 1'b0;
    req_if.valid  = 1'b0;
    req_if.cmd    = CMD_INSERT;
    req_if.value  = '0;
    req_idle_en   = 1'b0;
    res_stall_en  = 1'b0;
    hold_off_req  = 0;
    held_count    = 0;
    error_count   = 0;
    request_count = 0;
    result_count  = 0;
    full_rejects  = 0;
    empty_removes = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_remove_on_empty();
    test_fill_extremes_and_full();
    test_remove_ordered();
    test_random_phases();
    test_no_idle_stretch();
    test_backpressure();
    test_sender_pause();

    wait_results_drained();
    repeat (8) @(posedge clk);

    $display("covered %0d requests and %0d results, %0d inserts rejected as full,",
             request_count, result_count, full_rejects);
    $display("%0d removes on empty, long result hold-off and full drain pauses",
             empty_removes);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
